FILE: rtl/flp_pkg.sv
// Package for the frame parser: phase codes, result kinds, field widths and constants.
package flp_pkg;

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 16;
   localparam int POS_W   = 17;
   localparam int KIND_W  = 2;

   // Sync bytes and field sizes
   localparam logic [BYTE_W-1:0]  SYNC_FIRST   = 8'hAA;
   localparam logic [BYTE_W-1:0]  SYNC_SECOND  = 8'h55;
   localparam logic [COUNT_W-1:0] ADDR_BYTES   = 16'd5;
   localparam logic [COUNT_W-1:0] LEN_BYTES    = 16'd2;
   localparam logic [COUNT_W-1:0] HEADER_BYTES = 16'd4;
   localparam logic [COUNT_W-1:0] LIMIT_RESET  = 16'd1024;

   // Parser phase
   typedef enum logic [3:0] {
      PH_SYNC1 = 4'd0,
      PH_SYNC2 = 4'd1,
      PH_SRC   = 4'd2,
      PH_DST   = 4'd3,
      PH_LEN   = 4'd4,
      PH_VER   = 4'd5,
      PH_SER   = 4'd6,
      PH_CMD   = 4'd7,
      PH_DATA  = 4'd8,
      PH_CHK   = 4'd9
   } phase_type;

   // Result kind
   typedef enum logic [KIND_W-1:0] {
      KIND_BYTE   = 2'd0,
      KIND_GOOD   = 2'd1,
      KIND_SUMERR = 2'd2,
      KIND_LENERR = 2'd3
   } kind_type;

endpackage

FILE: rtl/flp_channels.sv
// Valid/ready channel interfaces for received bytes, results and the length limit register.
interface flp_req_if;
   logic                       valid;
   logic                       ready;
   logic [flp_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface flp_rsp_if;
   logic                        valid;
   logic                        ready;
   flp_pkg::kind_type           result_kind;
   logic [flp_pkg::BYTE_W-1:0]  frame_byte;
   logic [flp_pkg::POS_W-1:0]   byte_position;

   modport source (output valid, output result_kind, output frame_byte,
                   output byte_position, input ready);
   modport sink   (input valid, input result_kind, input frame_byte,
                   input byte_position, output ready);
endinterface

interface flp_csr_if;
   logic                        valid;
   logic                        ready;
   logic [flp_pkg::COUNT_W-1:0] length_limit;

   modport source (output valid, output length_limit, input ready);
   modport sink   (input valid, input length_limit, output ready);
endinterface

FILE: rtl/sync_length_checksum_frame_parser_top.sv
// Frame parser top level: input register, one-pass parse logic, result register.
//
// Usage:
//   req_ch carries one received byte per word. csr_ch writes the 16-bit
//   length limit (reset value 1024) and is always ready; the user writes it
//   only while the block is idle; the block does not enforce it. rsp_ch carries
//   at most one result per input word: a frame byte with its position, or a
//   frame end (good, checksum error, length error) with the frame length.
// Path: an accepted word is held in the input register; its result, if any,
//   is parsed from there and shown on rsp_ch from the result register.
// Throughput: one word per cycle unless rsp_ch stalls; the parse is a phase
//   update, 16-bit compare and 8-bit add between input and result registers.
// Stall: when a result waits and rsp_ch.ready is low, the parse stage holds;
//   req_ch.ready stays high until the input register is also occupied, so
//   one more word is taken while a result waits.
// Reset (synchronous, active high): both registers empty, parser hunting for
//   the first sync byte, counters and sum cleared, limit back to 1024.
module sync_length_checksum_frame_parser_top (
   input  logic           clock,
   input  logic           reset,
   flp_req_if.sink        req_ch,
   flp_rsp_if.source      rsp_ch,
   flp_csr_if.sink        csr_ch
);
   import flp_pkg::*;

   // Registers
   logic                 in_valid_ff;
   logic [BYTE_W-1:0]    in_byte_ff;
   logic                 out_valid_ff;
   kind_type             out_kind_ff;
   logic [BYTE_W-1:0]    out_byte_ff;
   logic [POS_W-1:0]     out_pos_ff;
   logic [COUNT_W-1:0]   limit_ff;
   phase_type            phase_ff, phase_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [BYTE_W-1:0]    sum_ff, sum_in;
   logic [BYTE_W-1:0]    len_lo_ff, len_lo_in;
   logic [POS_W-1:0]     pos_ff, pos_in;

   // Parse results
   logic                 emit;
   kind_type             kind;
   logic [BYTE_W-1:0]    obyte;
   logic [POS_W-1:0]     opos;

   // Helpers
   logic                 advance;
   logic                 proc;
   logic [BYTE_W-1:0]    b;
   logic [COUNT_W-1:0]   count_inc;
   logic [COUNT_W-1:0]   count_dec;
   logic [COUNT_W-1:0]   declared_len;
   logic [COUNT_W-1:0]   payload_left;
   logic [POS_W-1:0]     pos_plus;
   logic [BYTE_W-1:0]    sum_add;

   // Handshakes
   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign proc         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.result_kind   = out_kind_ff;
   assign rsp_ch.frame_byte    = out_byte_ff;
   assign rsp_ch.byte_position = out_pos_ff;

   // Arithmetic used by the phases
   assign b            = in_byte_ff;
   assign count_inc    = count_ff + 16'd1;
   assign count_dec    = count_ff - 16'd1;
   assign declared_len = {b, len_lo_ff};
   assign payload_left = (count_ff >= HEADER_BYTES) ? (count_ff - HEADER_BYTES) : '0;
   assign pos_plus     = pos_ff + 17'd1;
   assign sum_add      = sum_ff + b;

   // Next phase and result
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      len_lo_in = len_lo_ff;
      pos_in    = pos_ff;
      emit      = 1'b0;
      kind      = KIND_BYTE;
      obyte     = '0;
      opos      = pos_ff;
      unique case (phase_ff)
         PH_SYNC2: begin
            if (b == SYNC_SECOND) begin
               phase_in = PH_SRC;
               count_in = '0;
               emit     = 1'b1;
               obyte    = b;
               pos_in   = pos_plus;
            end
         end
         PH_SRC, PH_DST: begin
            emit     = 1'b1;
            obyte    = b;
            pos_in   = pos_plus;
            count_in = count_inc;
            if (count_inc >= ADDR_BYTES) begin
               phase_in = (phase_ff == PH_SRC) ? PH_DST : PH_LEN;
               count_in = '0;
            end
         end
         PH_LEN: begin
            if (count_inc < LEN_BYTES) begin
               count_in  = count_inc;
               len_lo_in = b;
               emit      = 1'b1;
               obyte     = b;
               pos_in    = pos_plus;
            end else begin
               count_in = declared_len;
               emit     = 1'b1;
               pos_in   = pos_plus;
               if (declared_len >= limit_ff) begin
                  phase_in = PH_SYNC1;
                  kind     = KIND_LENERR;
                  opos     = pos_plus;
               end else begin
                  phase_in = PH_VER;
                  sum_in   = '0;
                  obyte    = b;
               end
            end
         end
         PH_VER, PH_SER: begin
            sum_in   = sum_add;
            phase_in = (phase_ff == PH_VER) ? PH_SER : PH_CMD;
            emit     = 1'b1;
            obyte    = b;
            pos_in   = pos_plus;
         end
         PH_CMD: begin
            sum_in   = sum_add;
            count_in = payload_left;
            phase_in = (payload_left != '0) ? PH_DATA : PH_CHK;
            emit     = 1'b1;
            obyte    = b;
            pos_in   = pos_plus;
         end
         PH_DATA: begin
            sum_in   = sum_add;
            count_in = count_dec;
            if (count_dec == '0) begin
               phase_in = PH_CHK;
            end
            emit     = 1'b1;
            obyte    = b;
            pos_in   = pos_plus;
         end
         PH_CHK: begin
            phase_in = PH_SYNC1;
            emit     = 1'b1;
            kind     = (sum_ff == b) ? KIND_GOOD : KIND_SUMERR;
         end
         default: begin
            // hunting the first sync byte, also for unused phase codes
            if (b == SYNC_FIRST) begin
               phase_in = PH_SYNC2;
               emit     = 1'b1;
               obyte    = b;
               opos     = '0;
               pos_in   = 17'd1;
            end
         end
      endcase
   end

   // Control and parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         phase_ff     <= PH_SYNC1;
         count_ff     <= '0;
         sum_ff       <= '0;
         len_lo_ff    <= '0;
         pos_ff       <= '0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            out_valid_ff <= proc && emit;
         end
         if (csr_ch.valid) begin
            limit_ff <= csr_ch.length_limit;
         end
         if (proc) begin
            phase_ff  <= phase_in;
            count_ff  <= count_in;
            sum_ff    <= sum_in;
            len_lo_ff <= len_lo_in;
            pos_ff    <= pos_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.rx_byte;
      end
      if (proc && emit) begin
         out_kind_ff <= kind;
         out_byte_ff <= obyte;
         out_pos_ff  <= opos;
      end
   end

endmodule
